FILE: rtl/v3a_pkg.sv
// Shared types, constants and operation codes of the three-component vector unit.
package v3a_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SCALE_BITS    = 16;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_LEN   = 3'd5,
        OP_NORM  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [WORD_BITS-1:0]  a_x;
        logic signed [WORD_BITS-1:0]  a_y;
        logic signed [WORD_BITS-1:0]  a_z;
        logic signed [WORD_BITS-1:0]  b_x;
        logic signed [WORD_BITS-1:0]  b_y;
        logic signed [WORD_BITS-1:0]  b_z;
        logic signed [SCALE_BITS-1:0] scale;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] res_x;
        logic signed [WORD_BITS-1:0] res_y;
        logic signed [WORD_BITS-1:0] res_z;
        logic signed [WORD_BITS-1:0] res_scalar;
        logic                        saturated;
        logic                        zero_length;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]                  op;
        t_out_beat                   res;
        logic [2:0]                  neg;
        logic [2:0][WORD_BITS-1:0]   mag;
    } t_carry;

endpackage

FILE: rtl/v3a_front.sv
// Front pipeline: multiplies, sums and differences, rounding and clamping.
module v3a_front
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_in_beat                 i_in,
    output logic                     o_valid,
    output t_carry                   o_carry,
    output logic [2*WORD_BITS-1:0]   o_ss
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] WMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] WMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > WMAX) begin
            r = {1'b1, WMAX[W-1:0]};
        end else if (v < WMIN) begin
            r = {1'b1, WMIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    logic signed [W-1:0]  la [3];
    logic signed [W-1:0]  lb [3];
    logic signed [W-1:0]  lk;
    logic signed [W-1:0]  ma [6];
    logic signed [W-1:0]  mb [6];
    logic signed [PW-1:0] n1_p [6];
    logic signed [W:0]    n1_as [3];
    logic [2:0]           n1_neg;
    logic [2:0][W-1:0]    n1_mag;

    logic                 r1_valid;
    logic [2:0]           r1_op;
    logic signed [PW-1:0] r1_p [6];
    logic signed [W:0]    r1_as [3];
    logic [2:0]           r1_neg;
    logic [2:0][W-1:0]    r1_mag;

    logic signed [SW-1:0] n2_v [3];
    logic signed [SW-1:0] n2_s;

    logic                 r2_valid;
    logic [2:0]           r2_op;
    logic signed [SW-1:0] r2_v [3];
    logic signed [SW-1:0] r2_s;
    logic [2:0]           r2_neg;
    logic [2:0][W-1:0]    r2_mag;

    logic signed [SW-1:0] rv [3];
    logic signed [SW-1:0] rs;
    logic [W:0]           sv [3];
    logic [W:0]           sc;
    t_carry               n3_carry;

    logic                 r3_valid;
    t_carry               r3_carry;
    logic [PW-1:0]        r3_ss;

    always_comb begin
        la[0] = i_in.a_x;
        la[1] = i_in.a_y;
        la[2] = i_in.a_z;
        lb[0] = i_in.b_x;
        lb[1] = i_in.b_y;
        lb[2] = i_in.b_z;
        lk    = {{(W-SCALE_BITS){i_in.scale[SCALE_BITS-1]}}, i_in.scale};
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            ma[k] = '0;
            mb[k] = '0;
        end
        unique case (i_in.op)
            OP_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = la[k];
                    mb[k] = lk;
                end
            end
            OP_DOT: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = la[k];
                    mb[k] = lb[k];
                end
            end
            OP_CROSS: begin
                ma[0] = la[1]; mb[0] = lb[2];
                ma[1] = la[2]; mb[1] = lb[1];
                ma[2] = la[2]; mb[2] = lb[0];
                ma[3] = la[0]; mb[3] = lb[2];
                ma[4] = la[0]; mb[4] = lb[1];
                ma[5] = la[1]; mb[5] = lb[0];
            end
            OP_LEN, OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    ma[k] = la[k];
                    mb[k] = la[k];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n1_p[k] = ma[k] * mb[k];
        end
        for (int k = 0; k < 3; k++) begin
            if (i_in.op == OP_SUB) begin
                n1_as[k] = {la[k][W-1], la[k]} - {lb[k][W-1], lb[k]};
            end else begin
                n1_as[k] = {la[k][W-1], la[k]} + {lb[k][W-1], lb[k]};
            end
            n1_neg[k] = la[k][W-1];
            n1_mag[k] = la[k][W-1] ? W'(-la[k]) : la[k];
        end
    end

    always_comb begin
        n2_s = SW'(r1_p[0]) + SW'(r1_p[1]) + SW'(r1_p[2]);
        for (int k = 0; k < 3; k++) begin
            n2_v[k] = '0;
        end
        unique case (r1_op)
            OP_ADD, OP_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    n2_v[k] = SW'(r1_as[k]);
                end
            end
            OP_SCALE: begin
                for (int k = 0; k < 3; k++) begin
                    n2_v[k] = SW'(r1_p[k]);
                end
            end
            OP_CROSS: begin
                n2_v[0] = SW'(r1_p[0]) - SW'(r1_p[1]);
                n2_v[1] = SW'(r1_p[2]) - SW'(r1_p[3]);
                n2_v[2] = SW'(r1_p[4]) - SW'(r1_p[5]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rs = (r2_s + HALF) >>> FRAC_BITS;
        sc = sat_word(rs);
        for (int k = 0; k < 3; k++) begin
            rv[k] = (r2_v[k] + HALF) >>> FRAC_BITS;
            sv[k] = sat_word((r2_op == OP_CROSS) ? rv[k] : r2_v[k]);
        end
        n3_carry     = '0;
        n3_carry.op  = r2_op;
        n3_carry.neg = r2_neg;
        n3_carry.mag = r2_mag;
        unique case (r2_op)
            OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
                n3_carry.res.res_x     = sv[0][W-1:0];
                n3_carry.res.res_y     = sv[1][W-1:0];
                n3_carry.res.res_z     = sv[2][W-1:0];
                n3_carry.res.saturated = sv[0][W] | sv[1][W] | sv[2][W];
            end
            OP_DOT: begin
                n3_carry.res.res_scalar = sc[W-1:0];
                n3_carry.res.saturated  = sc[W];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op  <= i_in.op;
            r1_p   <= n1_p;
            r1_as  <= n1_as;
            r1_neg <= n1_neg;
            r1_mag <= n1_mag;
            r2_op  <= r1_op;
            r2_v   <= n2_v;
            r2_s   <= n2_s;
            r2_neg <= r1_neg;
            r2_mag <= r1_mag;
            r3_carry <= n3_carry;
            r3_ss    <= r2_s[PW-1:0];
        end
    end

    assign o_valid = r3_valid;
    assign o_carry = r3_carry;
    assign o_ss    = r3_ss;

endmodule

FILE: rtl/v3a_sqrt.sv
// Square-root pipeline, one root bit per stage, then round and length result.
module v3a_sqrt
    import v3a_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_carry                 i_carry,
    input  logic [2*WORD_BITS-1:0] i_ss,
    output logic                   o_valid,
    output t_carry                 o_carry,
    output logic [WORD_BITS:0]     o_len
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam logic [W:0] WMAXU = {2'b00, {(W-1){1'b1}}};

    logic [PW-1:0]  s_rad   [W];
    logic [W+1:0]   s_rem   [W];
    logic [W-1:0]   s_root  [W];
    t_carry         s_carry [W];
    logic [W-1:0]   s_valid;

    logic [W+3:0]   n_tmp   [W];
    logic [W+3:0]   n_trial [W];
    logic [PW-1:0]  n_rad   [W-1];
    logic [W+1:0]   n_rem   [W];
    logic [W-1:0]   n_root  [W];

    logic [PW-1:0]  r_rad   [W-1];
    logic [W+1:0]   r_rem   [W];
    logic [W-1:0]   r_root  [W];
    t_carry         r_carry [W];
    logic [W-1:0]   r_valid;

    logic [W:0]     n_len;
    t_carry         n_out;
    logic           r_lvalid;
    t_carry         r_lcarry;
    logic [W:0]     r_len;

    always_comb begin
        s_rad[0]   = i_ss;
        s_rem[0]   = '0;
        s_root[0]  = '0;
        s_carry[0] = i_carry;
        s_valid[0] = i_valid;
        for (int i = 1; i < W; i++) begin
            s_rad[i]   = r_rad[i-1];
            s_rem[i]   = r_rem[i-1];
            s_root[i]  = r_root[i-1];
            s_carry[i] = r_carry[i-1];
            s_valid[i] = r_valid[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < W; i++) begin
            n_tmp[i]   = {s_rem[i], s_rad[i][PW-1 -: 2]};
            n_trial[i] = {2'b00, s_root[i], 2'b01};
            if (n_tmp[i] >= n_trial[i]) begin
                n_rem[i]  = (W+2)'(n_tmp[i] - n_trial[i]);
                n_root[i] = {s_root[i][W-2:0], 1'b1};
            end else begin
                n_rem[i]  = n_tmp[i][W+1:0];
                n_root[i] = {s_root[i][W-2:0], 1'b0};
            end
        end
        for (int i = 0; i < W - 1; i++) begin
            n_rad[i] = s_rad[i] << 2;
        end
    end

    always_comb begin
        n_len = {1'b0, r_root[W-1]}
              + (W+1)'(r_rem[W-1] > {2'b00, r_root[W-1]});
        n_out = r_carry[W-1];
        if (r_carry[W-1].op == OP_LEN) begin
            if (n_len > WMAXU) begin
                n_out.res.res_scalar = WMAXU[W-1:0];
                n_out.res.saturated  = 1'b1;
            end else begin
                n_out.res.res_scalar = n_len[W-1:0];
            end
        end
        if (r_carry[W-1].op == OP_NORM && n_len == '0) begin
            n_out.res.zero_length = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_lvalid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= s_valid;
            r_lvalid <= r_valid[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < W; i++) begin
                r_rem[i]   <= n_rem[i];
                r_root[i]  <= n_root[i];
                r_carry[i] <= s_carry[i];
            end
            for (int i = 0; i < W - 1; i++) begin
                r_rad[i] <= n_rad[i];
            end
            r_lcarry <= n_out;
            r_len    <= n_len;
        end
    end

    assign o_valid = r_lvalid;
    assign o_carry = r_lcarry;
    assign o_len   = r_len;

endmodule

FILE: rtl/v3a_div.sv
// Normalize divider, one quotient bit per stage in three lanes, and output register.
module v3a_div
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_carry             i_carry,
    input  logic [WORD_BITS:0] i_len,
    output logic               o_valid,
    output t_out_beat          o_out
);

    localparam int W  = WORD_BITS;
    localparam int QB = FRAC_BITS + 2;
    localparam int NW = W + FRAC_BITS + 2;

    logic [NW-1:0]        n_num0 [3];

    logic [2:0][QB-1:0]   s_num   [QB];
    logic [2:0][W+1:0]    s_rem   [QB];
    logic [2:0][QB-1:0]   s_q     [QB];
    logic [W+1:0]         s_d     [QB];
    t_carry               s_carry [QB];
    logic [QB-1:0]        s_valid;

    logic [2:0][W+2:0]    n_tmp   [QB];
    logic [2:0][QB-1:0]   n_num   [QB-1];
    logic [2:0][W+1:0]    n_rem   [QB];
    logic [2:0][QB-1:0]   n_q     [QB];

    logic [2:0][QB-1:0]   r_num   [QB-1];
    logic [2:0][W+1:0]    r_rem   [QB];
    logic [2:0][QB-1:0]   r_q     [QB];
    logic [W+1:0]         r_d     [QB];
    t_carry               r_carry [QB];
    logic [QB-1:0]        r_valid;

    logic [W-1:0]         n_lim [3];
    logic [W-1:0]         n_qs  [3];
    logic [W-1:0]         n_val [3];
    logic [2:0]           n_sat;
    t_out_beat            n_out;

    logic                 r_ovalid;
    t_out_beat            r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num0[k]       = NW'({i_carry.mag[k], {(FRAC_BITS+1){1'b0}}}) + NW'(i_len);
            s_rem[0][k]     = (W+2)'(n_num0[k][NW-1:QB]);
            s_num[0][k]     = n_num0[k][QB-1:0];
        end
        s_q[0]     = '0;
        s_d[0]     = {i_len, 1'b0};
        s_carry[0] = i_carry;
        s_valid[0] = i_valid;
        for (int i = 1; i < QB; i++) begin
            s_num[i]   = r_num[i-1];
            s_rem[i]   = r_rem[i-1];
            s_q[i]     = r_q[i-1];
            s_d[i]     = r_d[i-1];
            s_carry[i] = r_carry[i-1];
            s_valid[i] = r_valid[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < QB; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_tmp[i][k] = {s_rem[i][k], s_num[i][k][QB-1]};
                if (n_tmp[i][k] >= {1'b0, s_d[i]}) begin
                    n_rem[i][k] = (W+2)'(n_tmp[i][k] - {1'b0, s_d[i]});
                    n_q[i][k]   = {s_q[i][k][QB-2:0], 1'b1};
                end else begin
                    n_rem[i][k] = n_tmp[i][k][W+1:0];
                    n_q[i][k]   = {s_q[i][k][QB-2:0], 1'b0};
                end
            end
        end
        for (int i = 0; i < QB - 1; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_num[i][k] = s_num[i][k] << 1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lim[k] = r_carry[QB-1].neg[k] ? {1'b1, {(W-1){1'b0}}}
                                             : {1'b0, {(W-1){1'b1}}};
            n_qs[k]  = W'(r_q[QB-1][k]);
            n_sat[k] = n_qs[k] > n_lim[k];
            if (n_sat[k]) begin
                n_qs[k] = n_lim[k];
            end
            n_val[k] = r_carry[QB-1].neg[k] ? (~n_qs[k] + 1'b1) : n_qs[k];
        end
        n_out = r_carry[QB-1].res;
        if (r_carry[QB-1].op == OP_NORM && r_d[QB-1] != '0) begin
            n_out.res_x     = n_val[0];
            n_out.res_y     = n_val[1];
            n_out.res_z     = n_val[2];
            n_out.saturated = |n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= s_valid;
            r_ovalid <= r_valid[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < QB; i++) begin
                r_rem[i]   <= n_rem[i];
                r_q[i]     <= n_q[i];
                r_d[i]     <= s_d[i];
                r_carry[i] <= s_carry[i];
            end
            for (int i = 0; i < QB - 1; i++) begin
                r_num[i] <= n_num[i];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule

FILE: rtl/vector3_alu.sv
// Three-component Q-format vector unit: add, subtract, scale, dot, cross, length, normalize.
// Fully pipelined: one beat in and one beat out per cycle unless the output stalls; the
// default format is Q16.16. Depth is set by the square-root pipeline (one root bit per stage)
// and the normalize divider (one quotient bit per stage). All stages advance together; a
// stalled output beat holds the whole pipeline.
module vector3_alu
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic                   w_en;
    logic                   w_f_valid;
    t_carry                 w_f_carry;
    logic [2*WORD_BITS-1:0] w_f_ss;
    logic                   w_s_valid;
    t_carry                 w_s_carry;
    logic [WORD_BITS:0]     w_s_len;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    v3a_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .o_carry (w_f_carry),
        .o_ss    (w_f_ss)
    );

    v3a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_carry (w_f_carry),
        .i_ss    (w_f_ss),
        .o_valid (w_s_valid),
        .o_carry (w_s_carry),
        .o_len   (w_s_len)
    );

    v3a_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_carry (w_s_carry),
        .i_len   (w_s_len),
        .o_valid (o_out_valid),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_zero_len_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.zero_length |->
            o_out.res_x == '0 && o_out.res_y == '0 && o_out.res_z == '0 &&
            o_out.res_scalar == '0 && !o_out.saturated)
        else $error("zero-length beat carries nonzero result");

    a_scalar_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.res_scalar != '0 |->
            o_out.res_x == '0 && o_out.res_y == '0 && o_out.res_z == '0)
        else $error("scalar and vector result both nonzero");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output beat valid right after reset");
`endif

endmodule

FILE: tb/sv/tb_vector3_alu.sv
// Self-checking testbench for the three-component fixed-point vector unit.
module tb_vector3_alu;
    import v3a_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LIMIT_CYC = 400000;
    localparam int DRAIN_CYC = 80;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out;

    vector3_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    t_in_beat  pending_beats[$];
    t_out_beat expected_results[$];
    int        mismatch_cnt;
    int        beats_taken;
    int        cycle_cnt;
    bit        drive_on;
    bit        in_took;
    int        send_idle;
    int        recv_stall;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [WORD_BITS-1:0] clamp_word(
        input logic signed [127:0] v, inout bit f);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (WORD_BITS - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) begin
            f = 1'b1;
            return hi[WORD_BITS-1:0];
        end
        if (v < lo) begin
            f = 1'b1;
            return lo[WORD_BITS-1:0];
        end
        return v[WORD_BITS-1:0];
    endfunction

    function automatic logic [127:0] sqrt_nearest(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] bitv;
        logic [127:0] t;
        root = '0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = root + bitv;
            if (n >= t) begin
                n    = n - t;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (root < n) root = root + 1;
        return root;
    endfunction

    function automatic logic signed [127:0] fix_round(input logic signed [127:0] v);
        return (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic t_out_beat vector_result(input t_in_beat b);
        logic signed [127:0] a [3];
        logic signed [127:0] c [3];
        logic signed [127:0] k;
        logic signed [127:0] s;
        logic [127:0]        ss;
        logic [127:0]        len;
        logic [127:0]        mag;
        logic [127:0]        q;
        logic [127:0]        lim;
        logic signed [WORD_BITS-1:0] r [3];
        logic signed [WORD_BITS-1:0] sc;
        bit                  sat;
        bit                  zl;
        t_out_beat           o;
        a[0] = b.a_x; a[1] = b.a_y; a[2] = b.a_z;
        c[0] = b.b_x; c[1] = b.b_y; c[2] = b.b_z;
        k = b.scale;
        r[0] = '0; r[1] = '0; r[2] = '0;
        sc = '0; sat = 1'b0; zl = 1'b0;
        case (b.op)
            OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + c[i], sat);
            OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - c[i], sat);
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] * k, sat);
            OP_DOT: begin
                s  = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
                sc = clamp_word(fix_round(s), sat);
            end
            OP_CROSS: begin
                r[0] = clamp_word(fix_round(a[1] * c[2] - a[2] * c[1]), sat);
                r[1] = clamp_word(fix_round(a[2] * c[0] - a[0] * c[2]), sat);
                r[2] = clamp_word(fix_round(a[0] * c[1] - a[1] * c[0]), sat);
            end
            OP_LEN, OP_NORM: begin
                ss  = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                len = sqrt_nearest(ss);
                if (b.op == OP_LEN) begin
                    sc = clamp_word($signed(len), sat);
                end else if (len == 0) begin
                    zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        mag = (a[i] < 0) ? -a[i] : a[i];
                        q   = ((mag << (FRAC + 1)) + len) / (len << 1);
                        lim = (128'd1 << (WORD_BITS - 1)) - ((a[i] < 0) ? 0 : 1);
                        if (q > lim) begin
                            sat = 1'b1;
                            q   = lim;
                        end
                        r[i] = (a[i] < 0) ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase
        o.res_x = r[0]; o.res_y = r[1]; o.res_z = r[2];
        o.res_scalar = sc; o.saturated = sat; o.zero_length = zl;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        mismatch_cnt++;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(524288)) - 262144;
            3:       return $signed($urandom_range(4096)) - 2048;
            4:       return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                               : 32'h8000_0000 + $urandom_range(3);
            default: return 32'd0;
        endcase
    endfunction

    function automatic t_in_beat mk_beat(input logic [2:0] op, input logic [31:0] ax,
        input logic [31:0] ay, input logic [31:0] az, input logic [31:0] bx,
        input logic [31:0] by, input logic [31:0] bz, input logic [15:0] k);
        t_in_beat t;
        t.op = op; t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz; t.scale = k;
        return t;
    endfunction

    initial begin
        t_in_beat t;
        logic [31:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        pending_beats.push_back(mk_beat(OP_ADD, mx, mn, 1, 1, mn, 32'hffff_ffff, 0));
        pending_beats.push_back(mk_beat(OP_SUB, mn, mx, 5, 1, mn, 3, 0));
        pending_beats.push_back(mk_beat(OP_SCALE, 32'h10000, mn, mx, 0, 0, 0, 16'h7fff));
        pending_beats.push_back(mk_beat(OP_SCALE, 32'h3, 32'hffff_fffd, 0, 0, 0, 0, 16'h8000));
        pending_beats.push_back(mk_beat(OP_SCALE, 1, 2, 3, 0, 0, 0, 16'hffff));
        pending_beats.push_back(mk_beat(OP_DOT, mx, mx, mx, mx, mx, mx, 0));
        pending_beats.push_back(mk_beat(OP_DOT, mn, mn, mn, mx, mx, mx, 0));
        pending_beats.push_back(mk_beat(OP_DOT, 32'h8000, 0, 0, 1, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_DOT, 32'h8000, 0, 0, 32'hffff_ffff, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_CROSS, mx, mn, mx, mn, mx, mn, 0));
        pending_beats.push_back(mk_beat(OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0));
        pending_beats.push_back(mk_beat(OP_LEN, mn, mn, mn, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_LEN, 32'h30000, 32'h40000, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_LEN, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NORM, 0, 0, 0, 1, 2, 3, 5));
        pending_beats.push_back(mk_beat(OP_NORM, mn, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NORM, mx, mx, mn, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(OP_NORM, 32'hffff_ffff, 1, 1, 0, 0, 0, 0));
        pending_beats.push_back(mk_beat(3'd7, mx, mn, 1, 2, 3, 4, 16'h1234));
        for (int n = 0; n < 1430; n++) begin
            t = mk_beat(3'($urandom_range(7)), rand_comp(), rand_comp(), rand_comp(),
                        rand_comp(), rand_comp(), rand_comp(), 16'($urandom));
            pending_beats.push_back(t);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        drive_on    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        drive_on = 1'b1;
    end

    always_comb begin
        case ((beats_taken / 180) % 4)
            0:       begin send_idle = 0;  recv_stall = 0;  end
            1:       begin send_idle = 48; recv_stall = 0;  end
            2:       begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 6;  recv_stall = 6;  end
        endcase
    end

    always @(negedge i_clk) begin
        if (drive_on) begin
            if (!i_in_valid || in_took) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_in       <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results.push_back(vector_result(i_in));
            beats_taken <= beats_taken + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("extra beat", o_out.res_x, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.res_x !== want.res_x)
                    report_mismatch("res_x", o_out.res_x, want.res_x);
                if (o_out.res_y !== want.res_y)
                    report_mismatch("res_y", o_out.res_y, want.res_y);
                if (o_out.res_z !== want.res_z)
                    report_mismatch("res_z", o_out.res_z, want.res_z);
                if (o_out.res_scalar !== want.res_scalar)
                    report_mismatch("res_scalar", o_out.res_scalar, want.res_scalar);
                if (o_out.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(o_out.saturated),
                                    32'(want.saturated));
                if (o_out.zero_length !== want.zero_length)
                    report_mismatch("zero_length", 32'(o_out.zero_length),
                                    32'(want.zero_length));
            end
        end
    end

    initial begin
        mismatch_cnt = 0;
        beats_taken  = 0;
        in_took      = 1'b0;
        wait (drive_on);
        wait (pending_beats.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("** vector3_alu: PASSED **");
        end else begin
            $display("** vector3_alu: FAILED **");
        end
        $finish;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= LIMIT_CYC) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("** vector3_alu: FAILED **");
                $finish;
            end
        end
    end

endmodule
